// File: hdl/k_way_sorted_merge_assert.svh
// ----------------------------------------------------------------------------
// k-way merge assertion macros
// concurrent checks with a reset qualifier, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef K_WAY_SORTED_MERGE_ASSERT_SVH
`define K_WAY_SORTED_MERGE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define KWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kwm assertion failed");

// next-cycle implication
`define KWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kwm assertion failed");

`else

`define KWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// shared widths, codes and parameter defaults of the k-way merge
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int LISTS_DEF      = 8;
    localparam int LIST_DEPTH_DEF = 64;
    localparam int VALUE_BITS_DEF = 16;

    localparam int OP_BITS     = 2;
    localparam int ID_BITS     = 3;
    localparam int DATA_BITS   = 16;
    localparam int STATUS_BITS = 2;
    localparam int CFG_BITS    = 4;

    typedef logic [OP_BITS-1:0]     t_op;
    typedef logic [STATUS_BITS-1:0] t_status;
    typedef logic [CFG_BITS-1:0]    t_cfg;

    localparam t_op OP_PUSH  = 2'd0;
    localparam t_op OP_POP   = 2'd1;
    localparam t_op OP_CLEAR = 2'd2;

    localparam t_status ST_DONE     = 2'd0;
    localparam t_status ST_EMPTY    = 2'd1;
    localparam t_status ST_FULL     = 2'd2;
    localparam t_status ST_BAD_LIST = 2'd3;

    localparam t_cfg ACTIVE_RESET = 4'd8;

endpackage

// File: hdl/kwm_if.sv
// ----------------------------------------------------------------------------
// kwm channel interfaces
// request, result and configuration channels with valid/ready
// ----------------------------------------------------------------------------
interface kwm_in_if;
    logic                                   valid;
    logic                                   ready;
    kwm_pkg::t_op                           op;
    logic [kwm_pkg::ID_BITS-1:0]            list_id;
    logic signed [kwm_pkg::DATA_BITS-1:0]   value;

    modport source (output valid, op, list_id, value, input ready);
    modport sink   (input valid, op, list_id, value, output ready);
endinterface

interface kwm_out_if;
    logic                                   valid;
    logic                                   ready;
    kwm_pkg::t_status                       status;
    logic signed [kwm_pkg::DATA_BITS-1:0]   value_out;
    logic [kwm_pkg::ID_BITS-1:0]            source_list;

    modport source (output valid, status, value_out, source_list, input ready);
    modport sink   (input valid, status, value_out, source_list, output ready);
endinterface

interface kwm_cfg_if;
    logic           valid;
    logic           ready;
    kwm_pkg::t_cfg  active_lists;

    modport source (output valid, active_lists, input ready);
    modport sink   (input valid, active_lists, output ready);
endinterface

// File: hdl/kwm_store.sv
// ----------------------------------------------------------------------------
// kwm_store
// value store of all lists, one write and one registered read port
// ----------------------------------------------------------------------------
module kwm_store #(
    parameter int DEPTH = kwm_pkg::LISTS_DEF * kwm_pkg::LIST_DEPTH_DEF,
    parameter int VB    = kwm_pkg::VALUE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [VB-1:0]            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [VB-1:0]            o_rdata
);

    logic [VB-1:0] r_mem [DEPTH];
    logic [VB-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/kwm_head_min.sv
// ----------------------------------------------------------------------------
// kwm_head_min
// compare tree over list heads, picks the smallest, highest index on ties
// ----------------------------------------------------------------------------
module kwm_head_min #(
    parameter int N  = kwm_pkg::LISTS_DEF,
    parameter int IW = $clog2(kwm_pkg::LISTS_DEF),
    parameter int VB = kwm_pkg::VALUE_BITS_DEF
) (
    input  logic          i_vld [N],
    input  logic [VB-1:0] i_val [N],
    output logic          o_found,
    output logic [IW-1:0] o_idx,
    output logic [VB-1:0] o_val
);

    localparam int P = 2 ** $clog2(N);

    logic          nv   [1:2*P-1];
    logic [VB-1:0] nval [1:2*P-1];
    logic [IW-1:0] nidx [1:2*P-1];

    always_comb begin
        for (int k = 0; k < P; k++) begin
            if (k < N) begin
                nv[P+k]   = i_vld[k];
                nval[P+k] = i_val[k];
            end else begin
                nv[P+k]   = 1'b0;
                nval[P+k] = '0;
            end
            nidx[P+k] = IW'(k);
        end
        // right child holds the higher indices, so it wins on equal keys
        for (int k = P - 1; k >= 1; k--) begin
            if (nv[2*k+1] && (!nv[2*k] || $signed(nval[2*k+1]) <= $signed(nval[2*k]))) begin
                nv[k]   = 1'b1;
                nval[k] = nval[2*k+1];
                nidx[k] = nidx[2*k+1];
            end else begin
                nv[k]   = nv[2*k];
                nval[k] = nval[2*k];
                nidx[k] = nidx[2*k];
            end
        end
    end

    assign o_found = nv[1];
    assign o_idx   = nidx[1];
    assign o_val   = nval[1];

endmodule

// File: hdl/k_way_sorted_merge.sv
// ----------------------------------------------------------------------------
// k_way_sorted_merge: per-list fifos in one store, pop returns smallest head
// the request is registered, executed in S_EXEC, and its result is registered
// no request is taken in S_EXEC or while a result waits; a pop refills its head
// from the store while the next request is taken
// reset: synchronous, empties all lists, active list count returns to 8
// ----------------------------------------------------------------------------
`include "k_way_sorted_merge_assert.svh"

module k_way_sorted_merge #(
    parameter int LISTS      = kwm_pkg::LISTS_DEF,
    parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF,
    parameter int VALUE_BITS = kwm_pkg::VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kwm_in_if.sink     i_in,
    kwm_out_if.source  o_out,
    kwm_cfg_if.sink    i_cfg
);

    localparam int LW      = $clog2(LISTS);
    localparam int DW      = $clog2(LIST_DEPTH);
    localparam int CW      = $clog2(LIST_DEPTH + 1);
    localparam int MDEPTH  = LISTS * LIST_DEPTH;
    localparam int AW      = $clog2(MDEPTH);
    localparam int ACTW    = $clog2(LISTS + 1);
    localparam int MAX_ACT = (1 << kwm_pkg::CFG_BITS) - 1;
    localparam int CAND    = (LISTS < MAX_ACT) ? LISTS : MAX_ACT;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_REFILL = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    kwm_pkg::t_cfg                   r_active;
    kwm_pkg::t_op                    r_op;
    logic [kwm_pkg::ID_BITS-1:0]     r_id;
    logic [VALUE_BITS-1:0]           r_val;
    logic [DW-1:0]                   r_rp   [LISTS];
    logic [CW-1:0]                   r_cnt  [LISTS];
    logic [VALUE_BITS-1:0]           r_head [LISTS];
    logic [LW-1:0]                   r_best;
    logic                            r_refill, n_refill;
    logic                            r_out_valid, n_out_valid;
    kwm_pkg::t_status                r_status, n_status;
    logic [kwm_pkg::DATA_BITS-1:0]   r_vout, n_vout;
    logic [kwm_pkg::ID_BITS-1:0]     r_src, n_src;

    logic [ACTW-1:0]       act;
    logic                  cand_vld [CAND];
    logic [VALUE_BITS-1:0] cand_val [CAND];
    logic                  best_found;
    logic [LW-1:0]         best_idx;
    logic [VALUE_BITS-1:0] best_val;

    logic                  in_take;
    logic [LW-1:0]         sel;
    logic [CW-1:0]         sel_cnt;
    logic [DW-1:0]         sel_rp;
    logic                  id_bad;
    logic [CW:0]           slot_sum;
    logic [DW-1:0]         wr_slot;
    logic [DW:0]           rp_inc;
    logic [DW-1:0]         nrp;

    logic                  upd_en;
    logic [CW-1:0]         upd_cnt;
    logic [DW-1:0]         upd_rp;
    logic                  upd_rp_en;
    logic                  clear_all;
    logic                  head_we;
    logic [LW-1:0]         head_idx;
    logic [VALUE_BITS-1:0] head_val;

    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         mem_addr;
    logic [VALUE_BITS-1:0] mem_rdata;

    // active count, out-of-range register values clamped
    always_comb begin
        if (r_active == '0) begin
            act = ACTW'(1);
        end else if (32'(r_active) > 32'(LISTS)) begin
            act = ACTW'(LISTS);
        end else begin
            act = ACTW'(r_active);
        end
    end

    always_comb begin
        for (int i = 0; i < CAND; i++) begin
            cand_vld[i] = (i < int'(act)) && (r_cnt[i] != '0);
            cand_val[i] = r_head[i];
        end
    end

    kwm_head_min #(
        .N  (CAND),
        .IW (LW),
        .VB (VALUE_BITS)
    ) u_head_min (
        .i_vld   (cand_vld),
        .i_val   (cand_val),
        .o_found (best_found),
        .o_idx   (best_idx),
        .o_val   (best_val)
    );

    assign in_take  = i_in.valid && i_in.ready;
    assign sel      = (r_op == kwm_pkg::OP_POP) ? best_idx : LW'(r_id);
    assign sel_cnt  = r_cnt[sel];
    assign sel_rp   = r_rp[sel];
    assign id_bad   = int'(r_id) >= int'(act);

    always_comb begin
        slot_sum = (CW + 1)'(sel_rp) + (CW + 1)'(sel_cnt);
        if (slot_sum >= (CW + 1)'(LIST_DEPTH)) begin
            wr_slot = DW'(slot_sum - (CW + 1)'(LIST_DEPTH));
        end else begin
            wr_slot = DW'(slot_sum);
        end
        rp_inc = (DW + 1)'(sel_rp) + (DW + 1)'(1);
        nrp    = (rp_inc == (DW + 1)'(LIST_DEPTH)) ? '0 : DW'(rp_inc);
    end

    always_comb begin
        n_state     = r_state;
        n_refill    = r_refill;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_vout      = r_vout;
        n_src       = r_src;
        upd_en      = 1'b0;
        upd_cnt     = sel_cnt;
        upd_rp      = sel_rp;
        upd_rp_en   = 1'b0;
        clear_all   = 1'b0;
        head_we     = 1'b0;
        head_idx    = sel;
        head_val    = r_val;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = AW'(sel) * AW'(LIST_DEPTH) + AW'(wr_slot);

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_out_valid = 1'b1;
                n_status    = kwm_pkg::ST_DONE;
                n_vout      = '0;
                n_src       = '0;
                n_state     = S_IDLE;
                case (r_op)
                    kwm_pkg::OP_PUSH: begin
                        if (id_bad) begin
                            n_status = kwm_pkg::ST_BAD_LIST;
                        end else if (sel_cnt == CW'(LIST_DEPTH)) begin
                            n_status = kwm_pkg::ST_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            upd_en  = 1'b1;
                            upd_cnt = sel_cnt + CW'(1);
                            // first value of an empty list is its head at once
                            head_we = (sel_cnt == '0);
                        end
                    end
                    kwm_pkg::OP_POP: begin
                        if (!best_found) begin
                            n_status = kwm_pkg::ST_EMPTY;
                        end else begin
                            n_vout    = kwm_pkg::DATA_BITS'(best_val);
                            n_src     = kwm_pkg::ID_BITS'(best_idx);
                            upd_en    = 1'b1;
                            upd_rp_en = 1'b1;
                            upd_cnt   = sel_cnt - CW'(1);
                            upd_rp    = nrp;
                            mem_re    = 1'b1;
                            mem_addr  = AW'(sel) * AW'(LIST_DEPTH) + AW'(nrp);
                            n_refill  = (sel_cnt != CW'(1));
                            n_state   = S_REFILL;
                        end
                    end
                    kwm_pkg::OP_CLEAR: begin
                        clear_all = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_REFILL: begin
                // next head arrives from the store
                head_we  = r_refill;
                head_idx = r_best;
                head_val = mem_rdata;
                n_state  = in_take ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    kwm_store #(
        .DEPTH (MDEPTH),
        .VB    (VALUE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_addr),
        .i_wdata (r_val),
        .i_re    (mem_re),
        .i_raddr (mem_addr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= kwm_pkg::ACTIVE_RESET;
            r_refill    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LISTS; i++) begin
                r_rp[i]  <= '0;
                r_cnt[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_refill    <= n_refill;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_active <= i_cfg.active_lists;
            end
            if (clear_all) begin
                for (int i = 0; i < LISTS; i++) begin
                    r_rp[i]  <= '0;
                    r_cnt[i] <= '0;
                end
            end else if (upd_en) begin
                r_cnt[sel] <= upd_cnt;
                if (upd_rp_en) begin
                    r_rp[sel] <= upd_rp;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op  <= i_in.op;
            r_id  <= i_in.list_id;
            r_val <= VALUE_BITS'(i_in.value);
        end
        if (head_we) begin
            r_head[head_idx] <= head_val;
        end
        if (r_state == S_EXEC) begin
            r_best <= best_idx;
        end
        r_status <= n_status;
        r_vout   <= n_vout;
        r_src    <= n_src;
    end

    assign i_in.ready        = i_rst_n && (r_state != S_EXEC) && (!r_out_valid || o_out.ready);
    assign i_cfg.ready       = i_rst_n;
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.value_out   = $signed(r_vout);
    assign o_out.source_list = r_src;

    `KWM_ASSERT_IMP(a_exec_blocks_input, i_clk, i_rst_n, r_state == S_EXEC, !i_in.ready)
    `KWM_ASSERT_NEXT(a_take_to_exec, i_clk, i_rst_n, in_take, r_state == S_EXEC)
    `KWM_ASSERT_NEXT(a_exec_gives_result, i_clk, i_rst_n, r_state == S_EXEC, o_out.valid)
    `KWM_ASSERT_IMP(a_refill_after_pop, i_clk, i_rst_n, r_state == S_REFILL, $past(r_state) == S_EXEC && $past(r_op) == kwm_pkg::OP_POP)
    `KWM_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, r_cnt[0] != '0, r_cnt[0] <= CW'(LIST_DEPTH))

endmodule
